// File: rtl/tail_drop_packet_queue_assert.svh
// Assertion macros used by the queue checker.
`ifndef TAIL_DROP_PACKET_QUEUE_ASSERT_SVH
`define TAIL_DROP_PACKET_QUEUE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define TDPQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("tail drop queue check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define TDPQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("tail drop queue check failed");

`endif

// File: rtl/tdpq_pkg.sv
package tdpq_pkg;

    localparam int ARR_W  = 32;
    localparam int DUR_W  = 16;
    localparam int TAG_W  = 16;
    localparam int TIME_W = 48;
    localparam int CFG_W  = 5;

    localparam int MAX_DEPTH_DEF = 16;

    localparam logic [CFG_W-1:0]  LIMIT_RESET = 5'd16;
    localparam logic [TIME_W-1:0] TIME_MAX    = {TIME_W{1'b1}};

    // One queued packet
    typedef struct packed {
        logic [ARR_W-1:0] arrival;
        logic [DUR_W-1:0] duration;
        logic [TAG_W-1:0] tag;
    } t_entry;

endpackage

// File: rtl/tdpq_in_if.sv
interface tdpq_in_if;
    logic                      valid;
    logic                      ready;
    logic [tdpq_pkg::ARR_W-1:0] arrival_time;
    logic [tdpq_pkg::DUR_W-1:0] duration;
    logic [tdpq_pkg::TAG_W-1:0] packet_tag;
    logic                      flush;

    modport source (output valid, output arrival_time, output duration,
                    output packet_tag, output flush, input ready);
    modport sink   (input valid, input arrival_time, input duration,
                    input packet_tag, input flush, output ready);
endinterface

// File: rtl/tdpq_out_if.sv
interface tdpq_out_if;
    logic                       valid;
    logic                       ready;
    logic [tdpq_pkg::TAG_W-1:0]  result_tag;
    logic                       served;
    logic [tdpq_pkg::TIME_W-1:0] start_time;
    logic                       last;

    modport source (output valid, output result_tag, output served,
                    output start_time, output last, input ready);
    modport sink   (input valid, input result_tag, input served,
                    input start_time, input last, output ready);
endinterface

// File: rtl/tdpq_cfg_if.sv
interface tdpq_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [tdpq_pkg::CFG_W-1:0] buffer_limit;

    modport source (output valid, output buffer_limit, input ready);
    modport sink   (input valid, input buffer_limit, output ready);
endinterface

// File: rtl/tail_drop_packet_queue.sv
// Tail-drop packet queue with a single server.
// i_in carries one arrival (arrival_time, duration, packet_tag) or a flush
// marker; a transfer happens when valid and ready are both high. i_cfg writes
// buffer_limit and is always ready; write it only while the block is idle.
// o_out carries one result per retired or dropped packet, last marking the
// final result of an input; an input that only enqueues gives no result.
// i_in.ready is high only while no item is in progress, so items are handled
// one at a time. An item is accepted, heads are tested and retired until one
// stays or the queue empties (no test if it starts empty), then the arrival
// is enqueued or dropped and the item closes out. Each head test goes head
// read, start time, finish time, decide, through the one head memory read
// port and one shared 48-bit comparator.
// A result is held in a pending register until the next one is known, then
// moves to the output register; when o_out.ready is low the sequencer waits
// and the output holds. Synchronous active-low reset empties the queue,
// clears busy time and output valid, and sets buffer_limit to 16; queue
// storage is not cleared, since only occupied entries are read.
module tail_drop_packet_queue #(
    parameter int MAX_DEPTH = tdpq_pkg::MAX_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tdpq_in_if.sink        i_in,
    tdpq_out_if.source     o_out,
    tdpq_cfg_if.sink       i_cfg
);

    localparam int PW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int OW = $clog2(MAX_DEPTH + 1);
    localparam int SW = OW + 1;
    localparam int LW = (OW > tdpq_pkg::CFG_W) ? OW : tdpq_pkg::CFG_W;
    localparam int TW = tdpq_pkg::TIME_W;

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_START, S_FINISH, S_DECIDE, S_TAIL, S_DONE
    } t_state;

    t_state r_state, n_state;

    logic [tdpq_pkg::ARR_W-1:0] r_arrival, n_arrival;
    logic [tdpq_pkg::DUR_W-1:0] r_dur, n_dur;
    logic [tdpq_pkg::TAG_W-1:0] r_tag, n_tag;
    logic                       r_flush, n_flush;
    logic [tdpq_pkg::CFG_W-1:0] r_limit, n_limit;
    logic [PW-1:0]              r_head, n_head;
    logic [OW-1:0]              r_occ, n_occ;
    logic [TW-1:0]              r_busy, n_busy;
    logic [TW-1:0]              r_start, n_start;
    logic [TW-1:0]              r_finish, n_finish;

    logic                       r_pend_v, n_pend_v;
    logic [tdpq_pkg::TAG_W-1:0] r_pend_tag, n_pend_tag;
    logic                       r_pend_served, n_pend_served;
    logic [TW-1:0]              r_pend_start, n_pend_start;

    logic                       r_out_v, n_out_v;
    logic [tdpq_pkg::TAG_W-1:0] r_out_tag, n_out_tag;
    logic                       r_out_served, n_out_served;
    logic [TW-1:0]              r_out_start, n_out_start;
    logic                       r_out_last, n_out_last;

    tdpq_pkg::t_entry rd_entry;
    tdpq_pkg::t_entry wr_entry;
    logic             wr_en;
    logic [PW-1:0]    tail_addr;
    logic [SW-1:0]    tail_sum;
    logic             room;
    logic [LW-1:0]    lim_eff;

    logic [TW-1:0]    cmp_a, cmp_b;
    logic             cmp_lt;
    logic [TW:0]      fin_sum;
    logic             out_free;
    logic             can_emit;

    tdpq_store #(.DEPTH(MAX_DEPTH), .PW(PW)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (tail_addr),
        .i_wr_data (wr_entry),
        .i_rd_addr (r_head),
        .o_rd_data (rd_entry)
    );

    // Tail slot and room against the clamped limit
    assign tail_sum  = SW'(r_head) + SW'(r_occ);
    assign tail_addr = (tail_sum >= SW'(MAX_DEPTH)) ? PW'(tail_sum - SW'(MAX_DEPTH))
                                                    : PW'(tail_sum);
    assign lim_eff   = (LW'(r_limit) > LW'(MAX_DEPTH)) ? LW'(MAX_DEPTH) : LW'(r_limit);
    assign room      = LW'(r_occ) < lim_eff;

    assign wr_entry = '{arrival: r_arrival, duration: r_dur, tag: r_tag};
    assign wr_en    = (r_state == S_TAIL) && !r_flush && room;

    // Shared comparator: busy vs. arrival, then arrival vs. finish
    always_comb begin
        cmp_a = '0;
        cmp_b = '0;
        case (r_state)
            S_START: begin
                cmp_a = r_busy;
                cmp_b = TW'(rd_entry.arrival);
            end
            S_DECIDE: begin
                cmp_a = TW'(r_arrival);
                cmp_b = r_finish;
            end
            default: begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end
    assign cmp_lt = cmp_a < cmp_b;

    assign fin_sum  = {1'b0, r_start} + (TW + 1)'(rd_entry.duration);
    assign out_free = !r_out_v || o_out.ready;
    assign can_emit = !r_pend_v || out_free;

    // Sequencer next state
    always_comb begin
        n_state       = r_state;
        n_arrival     = r_arrival;
        n_dur         = r_dur;
        n_tag         = r_tag;
        n_flush       = r_flush;
        n_limit       = r_limit;
        n_head        = r_head;
        n_occ         = r_occ;
        n_busy        = r_busy;
        n_start       = r_start;
        n_finish      = r_finish;
        n_pend_v      = r_pend_v;
        n_pend_tag    = r_pend_tag;
        n_pend_served = r_pend_served;
        n_pend_start  = r_pend_start;
        n_out_v       = r_out_v;
        n_out_tag     = r_out_tag;
        n_out_served  = r_out_served;
        n_out_start   = r_out_start;
        n_out_last    = r_out_last;

        // Drop output valid once the receiver takes it
        if (r_out_v && o_out.ready) begin
            n_out_v = 1'b0;
        end

        if (i_cfg.valid) begin
            n_limit = i_cfg.buffer_limit;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_arrival = i_in.arrival_time;
                    n_dur     = i_in.duration;
                    n_tag     = i_in.packet_tag;
                    n_flush   = i_in.flush;
                    n_state   = S_READ;
                end
            end
            S_READ: begin
                n_state = (r_occ == '0) ? S_TAIL : S_START;
            end
            S_START: begin
                n_start = cmp_lt ? TW'(rd_entry.arrival) : r_busy;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                n_finish = fin_sum[TW] ? tdpq_pkg::TIME_MAX : fin_sum[TW-1:0];
                n_state  = S_DECIDE;
            end
            S_DECIDE: begin
                if (!r_flush && cmp_lt) begin
                    n_state = S_TAIL;
                end else if (can_emit) begin
                    // Retire head: move older result out, hold this one
                    if (r_pend_v) begin
                        n_out_v      = 1'b1;
                        n_out_tag    = r_pend_tag;
                        n_out_served = r_pend_served;
                        n_out_start  = r_pend_start;
                        n_out_last   = 1'b0;
                    end
                    n_pend_v      = 1'b1;
                    n_pend_tag    = rd_entry.tag;
                    n_pend_served = 1'b1;
                    n_pend_start  = r_start;
                    n_busy        = r_finish;
                    n_head        = (r_head == PW'(MAX_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    n_occ         = r_occ - 1'b1;
                    n_state       = S_READ;
                end
            end
            S_TAIL: begin
                if (r_flush) begin
                    n_state = S_DONE;
                end else if (room) begin
                    n_occ   = r_occ + 1'b1;
                    n_state = S_DONE;
                end else if (can_emit) begin
                    // Drop the arrival
                    if (r_pend_v) begin
                        n_out_v      = 1'b1;
                        n_out_tag    = r_pend_tag;
                        n_out_served = r_pend_served;
                        n_out_start  = r_pend_start;
                        n_out_last   = 1'b0;
                    end
                    n_pend_v      = 1'b1;
                    n_pend_tag    = r_tag;
                    n_pend_served = 1'b0;
                    n_pend_start  = '0;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_v      = 1'b1;
                    n_out_tag    = r_pend_tag;
                    n_out_served = r_pend_served;
                    n_out_start  = r_pend_start;
                    n_out_last   = 1'b1;
                    n_pend_v     = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_limit  <= tdpq_pkg::LIMIT_RESET;
            r_head   <= '0;
            r_occ    <= '0;
            r_busy   <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_limit  <= n_limit;
            r_head   <= n_head;
            r_occ    <= n_occ;
            r_busy   <= n_busy;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
        r_arrival     <= n_arrival;
        r_dur         <= n_dur;
        r_tag         <= n_tag;
        r_flush       <= n_flush;
        r_start       <= n_start;
        r_finish      <= n_finish;
        r_pend_tag    <= n_pend_tag;
        r_pend_served <= n_pend_served;
        r_pend_start  <= n_pend_start;
        r_out_tag     <= n_out_tag;
        r_out_served  <= n_out_served;
        r_out_start   <= n_out_start;
        r_out_last    <= n_out_last;
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_out_v;
    assign o_out.result_tag = r_out_tag;
    assign o_out.served     = r_out_served;
    assign o_out.start_time = r_out_start;
    assign o_out.last       = r_out_last;

endmodule

// File: rtl/tdpq_store.sv
module tdpq_store #(
    parameter int DEPTH = tdpq_pkg::MAX_DEPTH_DEF,
    parameter int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [PW-1:0]    i_wr_addr,
    input  tdpq_pkg::t_entry i_wr_data,
    input  logic [PW-1:0]    i_rd_addr,
    output tdpq_pkg::t_entry o_rd_data
);

    tdpq_pkg::t_entry r_mem [DEPTH];
    tdpq_pkg::t_entry r_rd;

    // Write the tail entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Register the head entry
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule

// File: rtl/tdpq_checker.sv
`include "tail_drop_packet_queue_assert.svh"

module tdpq_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [tdpq_pkg::TAG_W-1:0]  i_out_tag,
    input logic                        i_out_served,
    input logic [tdpq_pkg::TIME_W-1:0] i_out_start,
    input logic                        i_out_last
);

    // Stalled result holds
    `TDPQ_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_tag) && $stable(i_out_served) && $stable(i_out_start) && $stable(i_out_last))

    // One item at a time: busy right after a transfer in
    `TDPQ_ASSERT_NEXT(a_busy_after_accept, i_in_valid && i_in_ready, !i_in_ready)

    // Dropped packets report zero start time
    `TDPQ_ASSERT_NOW(a_drop_zero_start, i_out_valid && !i_out_served, i_out_start == '0)

    // An unfinished result sequence keeps the input closed
    `TDPQ_ASSERT_NOW(a_no_accept_mid_item, i_out_valid && !i_out_last, !i_in_ready)

endmodule

bind tail_drop_packet_queue tdpq_checker u_tdpq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_tag    (o_out.result_tag),
    .i_out_served (o_out.served),
    .i_out_start  (o_out.start_time),
    .i_out_last   (o_out.last)
);
